// ===== rtl/sbr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types and constants of the symbol name back-reference decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sbr_pkg;

  // parser phase codes
  localparam logic [1:0] PhCode = 2'd0;
  localparam logic [1:0] PhLen  = 2'd1;
  localparam logic [1:0] PhDist = 2'd2;

  // sticky fault codes
  localparam logic [1:0] FaultNone  = 2'd0;
  localparam logic [1:0] FaultDist  = 2'd1;
  localparam logic [1:0] FaultTrunc = 2'd2;
  localparam logic [1:0] FaultSat   = 2'd3;

  localparam logic [7:0]  LongOpen   = 8'h80;
  localparam logic [7:0]  DotChar    = 8'h2e;
  localparam logic [7:0]  DotReset   = 8'h40;
  localparam logic [13:0] LenMax     = 14'h3fff;
  localparam logic [6:0]  ShortBias  = 7'd7;
  localparam logic [6:0]  RamDistMin = 7'd9;

  localparam int WinDepth = 8;
  localparam int WinAw    = 3;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       final_byte;
  } sbr_in_t;

  typedef struct packed {
    logic [7:0]  char_first;
    logic [7:0]  char_second;
    logic [1:0]  char_count;
    logic [13:0] name_length;
    logic [1:0]  fault;
    logic        end_of_name;
  } sbr_out_t;

  // work for one code byte, handed from the parser to the copy engine
  typedef struct packed {
    logic [6:0] n_chars;
    logic [6:0] back_dist;
    logic [7:0] lit;
    logic       is_lit;
    logic       use_ram;
    logic       emit_empty;
    logic       last;
    logic [1:0] fault;
  } sbr_plan_t;

  function automatic logic [7:0] dot_map(input logic [7:0] c, input logic [7:0] sub);
    dot_map = (c == DotChar) ? sub : c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/symbol_name_backref_decoder.sv =====
// ----------------------------------------------------------------------------
// symbol_name_backref_decoder
// Decodes back-reference compressed symbol names into characters.
// ----------------------------------------------------------------------------
// Input channel: one code byte per beat, final_byte set on the name's last
// byte. Output channel: result beats of up to two characters, each with the
// running name length, the sticky fault code and an end-of-name flag.
// Configuration channel: writes the character shown in place of '.'.
// One byte is worked on at a time; a new byte is taken only once the current
// one is done. A reference with a distance of 9 or more is served from the
// banked history memory, written two characters at a time, with registered
// read data; shorter ones come from the recent-character window. Results are
// registered, and a memory copy also passes through the memory read register.
// While a result waits for the receiver, decoding holds, but a new byte can
// still be taken once the current one is done.
// Reset clears the parser, the name length and the result valid flag; the
// history memory has no clearing pass and needs none, since distances are
// checked against characters already decoded in the current name.
// ----------------------------------------------------------------------------
`default_nettype none

module symbol_name_backref_decoder #(
  parameter int HISTORY_DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sbr_pkg::sbr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sbr_pkg::sbr_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i
);
  import sbr_pkg::*;

  logic       idle;
  logic       accept;
  logic [13:0] pos;
  logic [7:0] dot_sub_q;
  sbr_plan_t  plan;

  assign in_ready_o  = idle;
  assign accept      = in_valid_i && idle;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_sub_q <= DotReset;
    end else if (cfg_valid_i) begin
      dot_sub_q <= cfg_data_i;
    end
  end

  sbr_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .pos_i     (pos),
    .plan_o    (plan)
  );

  sbr_copy #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_copy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .plan_i      (plan),
    .dot_sub_i   (dot_sub_q),
    .idle_o      (idle),
    .pos_o       (pos),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/sbr_ram.sv =====
// ----------------------------------------------------------------------------
// sbr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/sbr_parse.sv =====
// ----------------------------------------------------------------------------
// sbr_parse
// Code byte parser: tracks the long-reference phase, halt and fault state,
// checks distances and length, and plans the work for each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  sbr_pkg::sbr_in_t   in_data_i,
  input  logic [13:0]        pos_i,
  output sbr_pkg::sbr_plan_t plan_o
);
  import sbr_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [6:0]  plen_q, plen_d;
  logic        halted_q, halted_d;
  logic [1:0]  fault_q, fault_d;

  logic [7:0]  b;
  logic        last;
  logic        do_ref, is_lit, trunc, short_neg, dist_bad, sat;
  logic [6:0]  len, back_dist, n_chars;
  logic [13:0] avail;
  logic [1:0]  new_fault;

  always_comb begin
    b         = in_data_i.code_byte;
    last      = in_data_i.final_byte;
    phase_d   = phase_q;
    plen_d    = plen_q;
    do_ref    = 1'b0;
    is_lit    = 1'b0;
    trunc     = 1'b0;
    short_neg = 1'b0;
    len       = 7'd0;
    back_dist = 7'd0;
    if (!halted_q) begin
      unique case (phase_q)
        PhLen: begin
          plen_d = b[6:0];
          if (last) begin
            trunc = 1'b1;
          end else begin
            phase_d = PhDist;
          end
        end
        PhDist: begin
          phase_d   = PhCode;
          do_ref    = 1'b1;
          len       = plen_q;
          back_dist = b[6:0];
        end
        default: begin
          if (b == LongOpen) begin
            if (last) begin
              trunc = 1'b1;
            end else begin
              phase_d = PhLen;
            end
          end else if (b[7]) begin
            do_ref    = 1'b1;
            len       = {4'd0, b[2:0]} + 7'd1;
            back_dist = {3'd0, b[6:3]} - ShortBias;
            short_neg = !b[6];
          end else begin
            do_ref = 1'b1;
            is_lit = 1'b1;
            len    = 7'd1;
          end
        end
      endcase
    end

    avail    = LenMax - pos_i;
    dist_bad = do_ref && !is_lit &&
               (short_neg || back_dist == 7'd0 || {7'd0, back_dist} > pos_i);
    sat      = do_ref && !dist_bad && ({7'd0, len} > avail);
    n_chars  = (do_ref && !dist_bad) ? (sat ? avail[6:0] : len) : 7'd0;

    if (trunc) begin
      new_fault = FaultTrunc;
    end else if (dist_bad) begin
      new_fault = FaultDist;
    end else if (sat) begin
      new_fault = FaultSat;
    end else begin
      new_fault = FaultNone;
    end

    halted_d = halted_q;
    fault_d  = fault_q;
    if (new_fault != FaultNone) begin
      halted_d = 1'b1;
      fault_d  = new_fault;
    end

    plan_o.n_chars    = n_chars;
    plan_o.back_dist  = back_dist;
    plan_o.lit        = b;
    plan_o.is_lit     = is_lit;
    plan_o.use_ram    = !is_lit && (back_dist >= RamDistMin);
    plan_o.emit_empty = (n_chars == 7'd0) && (last || new_fault != FaultNone);
    plan_o.last       = last;
    plan_o.fault      = fault_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhCode;
      plen_q   <= 7'd0;
      halted_q <= 1'b0;
      fault_q  <= FaultNone;
    end else if (accept_i) begin
      if (in_data_i.final_byte) begin
        phase_q  <= PhCode;
        plen_q   <= 7'd0;
        halted_q <= 1'b0;
        fault_q  <= FaultNone;
      end else begin
        phase_q  <= phase_d;
        plen_q   <= plen_d;
        halted_q <= halted_d;
        fault_q  <= fault_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sbr_copy.sv =====
// ----------------------------------------------------------------------------
// sbr_copy
// Copy engine: writes decoded characters into a two-bank history memory,
// serves short distances from a recent-character window and long ones from
// the memory, and packs up to two characters per result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_copy #(
  parameter int HISTORY_DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  sbr_pkg::sbr_plan_t plan_i,
  input  logic [7:0]         dot_sub_i,
  output logic               idle_o,
  output logic [13:0]        pos_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sbr_pkg::sbr_out_t  out_data_o
);
  import sbr_pkg::*;

  localparam int HistAw    = $clog2(HISTORY_DEPTH);
  localparam int BankAw    = HistAw - 1;
  localparam int BankDepth = HISTORY_DEPTH / 2;

  // control
  logic        busy_q, busy_d;
  logic        ram_q, ram_d;
  logic        empty_q, empty_d;
  logic        last_q, last_d;
  logic [1:0]  sfault_q, sfault_d;
  logic [6:0]  left_q, left_d;
  logic [6:0]  rd_left_q, rd_left_d;
  logic        d_vld_q, d_vld_d;
  logic [13:0] pos_q, pos_d;
  logic        out_valid_q, out_valid_d;

  // payload
  logic [7:0]        lit_q;
  logic              is_lit_q;
  logic [6:0]        dist_q;
  logic [HistAw-1:0] rd_src_q;
  logic [1:0]        d_cnt_q;
  logic              d_par_q;
  logic [7:0]        win_q [WinDepth];
  sbr_out_t          out_q;

  logic              out_free, prod_w, prod_r, prod_e, prod_c, done, issue;
  logic [WinAw-1:0]  win_a_idx, win_b_idx;
  logic [7:0]        w_a, w_b, r_a, r_b, ch_a, ch_b;
  logic [1:0]        w_cnt, cnt, ic;
  logic [HistAw-1:0] a0, a1;
  logic [13:0]       p1;
  logic [BankAw-1:0] ev_raddr, od_raddr, ev_waddr, od_waddr;
  logic              ev_we, od_we;
  logic [7:0]        ev_wdata, od_wdata, ev_rdata, od_rdata;
  sbr_out_t          res;

  sbr_ram #(.WIDTH(8), .DEPTH(BankDepth)) u_even (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (ev_waddr),
    .wdata_i (ev_wdata),
    .re_i    (issue),
    .raddr_i (ev_raddr),
    .rdata_o (ev_rdata)
  );

  sbr_ram #(.WIDTH(8), .DEPTH(BankDepth)) u_odd (
    .clk_i   (clk_i),
    .we_i    (od_we),
    .waddr_i (od_waddr),
    .wdata_i (od_wdata),
    .re_i    (issue),
    .raddr_i (od_raddr),
    .rdata_o (od_rdata)
  );

  always_comb begin
    win_a_idx = WinAw'(dist_q - 7'd1);
    win_b_idx = WinAw'(dist_q - 7'd2);
    w_a       = is_lit_q ? lit_q : win_q[win_a_idx];
    w_b       = (dist_q == 7'd1) ? w_a : win_q[win_b_idx];
    w_cnt     = (left_q >= 7'd2) ? 2'd2 : 2'd1;
    r_a       = d_par_q ? od_rdata : ev_rdata;
    r_b       = d_par_q ? ev_rdata : od_rdata;
    ch_a      = ram_q ? r_a : w_a;
    ch_b      = ram_q ? r_b : w_b;
    cnt       = ram_q ? d_cnt_q : w_cnt;

    out_free  = !out_valid_q || out_ready_i;
    prod_w    = busy_q && !ram_q && !empty_q && (left_q != 7'd0) && out_free;
    prod_r    = busy_q && ram_q && d_vld_q && out_free;
    prod_e    = busy_q && empty_q && out_free;
    prod_c    = prod_w || prod_r;
    done      = busy_q && ((left_q == 7'd0 && !empty_q) || prod_e ||
                           (prod_c && left_q == {5'd0, cnt}));

    // memory read side
    issue     = busy_q && ram_q && (rd_left_q != 7'd0) && (!d_vld_q || prod_r);
    ic        = (rd_left_q >= 7'd2) ? 2'd2 : 2'd1;
    a0        = rd_src_q;
    a1        = rd_src_q + HistAw'(1);
    ev_raddr  = a0[0] ? a1[HistAw-1:1] : a0[HistAw-1:1];
    od_raddr  = a0[0] ? a0[HistAw-1:1] : a1[HistAw-1:1];

    // memory write side
    p1        = pos_q + 14'd1;
    ev_we     = prod_c && (!pos_q[0] || cnt == 2'd2);
    od_we     = prod_c && (pos_q[0] || cnt == 2'd2);
    ev_waddr  = pos_q[0] ? p1[HistAw-1:1] : pos_q[HistAw-1:1];
    od_waddr  = pos_q[0] ? pos_q[HistAw-1:1] : p1[HistAw-1:1];
    ev_wdata  = pos_q[0] ? ch_b : ch_a;
    od_wdata  = pos_q[0] ? ch_a : ch_b;

    // result beat
    if (prod_e) begin
      res.char_first  = 8'd0;
      res.char_second = 8'd0;
      res.char_count  = 2'd0;
      res.name_length = pos_q;
      res.end_of_name = last_q;
    end else begin
      res.char_first  = dot_map(ch_a, dot_sub_i);
      res.char_second = (cnt == 2'd2) ? dot_map(ch_b, dot_sub_i) : 8'd0;
      res.char_count  = cnt;
      res.name_length = pos_q + {12'd0, cnt};
      res.end_of_name = last_q && (left_q == {5'd0, cnt});
    end
    res.fault = sfault_q;
  end

  always_comb begin
    busy_d      = busy_q;
    ram_d       = ram_q;
    empty_d     = empty_q;
    last_d      = last_q;
    sfault_d    = sfault_q;
    left_d      = left_q;
    rd_left_d   = rd_left_q;
    d_vld_d     = d_vld_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (prod_c || prod_e) begin
      out_valid_d = 1'b1;
    end

    if (start_i) begin
      busy_d    = 1'b1;
      ram_d     = plan_i.use_ram;
      empty_d   = plan_i.emit_empty;
      last_d    = plan_i.last;
      sfault_d  = plan_i.fault;
      left_d    = plan_i.n_chars;
      rd_left_d = plan_i.n_chars;
      d_vld_d   = 1'b0;
    end

    if (issue) begin
      rd_left_d = rd_left_q - {5'd0, ic};
      d_vld_d   = 1'b1;
    end else if (prod_r) begin
      d_vld_d = 1'b0;
    end

    if (prod_c) begin
      left_d = left_q - {5'd0, cnt};
      pos_d  = pos_q + {12'd0, cnt};
    end
    if (prod_e) begin
      empty_d = 1'b0;
    end

    if (done) begin
      busy_d = 1'b0;
      if (last_q) begin
        pos_d = 14'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ram_q       <= 1'b0;
      empty_q     <= 1'b0;
      last_q      <= 1'b0;
      sfault_q    <= FaultNone;
      left_q      <= 7'd0;
      rd_left_q   <= 7'd0;
      d_vld_q     <= 1'b0;
      pos_q       <= 14'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      ram_q       <= ram_d;
      empty_q     <= empty_d;
      last_q      <= last_d;
      sfault_q    <= sfault_d;
      left_q      <= left_d;
      rd_left_q   <= rd_left_d;
      d_vld_q     <= d_vld_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lit_q    <= plan_i.lit;
      is_lit_q <= plan_i.is_lit;
      dist_q   <= plan_i.back_dist;
      rd_src_q <= pos_q[HistAw-1:0] - plan_i.back_dist[HistAw-1:0];
    end else if (issue) begin
      rd_src_q <= rd_src_q + HistAw'(2);
    end
    if (issue) begin
      d_cnt_q <= ic;
      d_par_q <= a0[0];
    end
    if (prod_c) begin
      if (cnt == 2'd2) begin
        win_q[0] <= ch_b;
        win_q[1] <= ch_a;
        for (int i = 2; i < WinDepth; i++) begin
          win_q[i] <= win_q[i-2];
        end
      end else begin
        win_q[0] <= ch_a;
        for (int i = 1; i < WinDepth; i++) begin
          win_q[i] <= win_q[i-1];
        end
      end
    end
    if (prod_c || prod_e) begin
      out_q <= res;
    end
  end

  assign idle_o      = !busy_q;
  assign pos_o       = pos_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ram_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && ram_q |-> left_q == rd_left_q + (d_vld_q ? {5'd0, d_cnt_q} : 7'd0))
    else $error("copy engine lost track of characters in flight");

  a_read_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld_q |-> busy_q && ram_q)
    else $error("history read data pending outside a memory copy");

  a_empty_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && empty_q |-> left_q == 7'd0)
    else $error("empty result planned for a beat that copies characters");

  a_name_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && last_q |=> pos_q == 14'd0)
    else $error("name length not cleared after the last byte");

endmodule

`default_nettype wire
